### design/source_token_scanner_top_assert.svh
// Assertion macros for the source token scanner.
// Used by source_token_scanner_top.sv; depends on nothing else.
`ifndef SOURCE_TOKEN_SCANNER_TOP_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_TOP_ASSERT_SVH

// Implication checked outside reset.
`define STS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/stc_pkg.sv
// Shared types, constants and byte classing for the source token scanner.
// Used by stc_front, stc_core and source_token_scanner_top; no dependencies.
`default_nettype none

package stc_pkg;

   localparam int QUEUE_DEPTH = 4;

   // token kinds
   localparam logic [4:0] KIND_END      = 5'd0;
   localparam logic [4:0] KIND_IDENT    = 5'd1;
   localparam logic [4:0] KIND_KEYWORD  = 5'd2;
   localparam logic [4:0] KIND_MULTI    = 5'd3;
   localparam logic [4:0] KIND_INTEGER  = 5'd4;
   localparam logic [4:0] KIND_FLOAT    = 5'd5;
   localparam logic [4:0] KIND_CHAR     = 5'd6;
   localparam logic [4:0] KIND_STRING   = 5'd7;
   localparam logic [4:0] KIND_SYMBOL   = 5'd8;
   localparam logic [4:0] KIND_LPAREN   = 5'd9;
   localparam logic [4:0] KIND_RPAREN   = 5'd10;
   localparam logic [4:0] KIND_LBRACK   = 5'd11;
   localparam logic [4:0] KIND_RBRACK   = 5'd12;
   localparam logic [4:0] KIND_LCURLY   = 5'd13;
   localparam logic [4:0] KIND_RCURLY   = 5'd14;
   localparam logic [4:0] KIND_SEMI     = 5'd15;
   localparam logic [4:0] KIND_DOT      = 5'd16;
   localparam logic [4:0] KIND_BAR      = 5'd17;
   localparam logic [4:0] KIND_OPER     = 5'd18;
   localparam logic [4:0] KIND_LT       = 5'd19;
   localparam logic [4:0] KIND_GT       = 5'd20;
   localparam logic [4:0] KIND_BYTEARR  = 5'd21;
   localparam logic [4:0] KIND_LITARR   = 5'd22;
   localparam logic [4:0] ERR_COMMENT   = 5'd23;
   localparam logic [4:0] ERR_SYMSTR    = 5'd24;
   localparam logic [4:0] ERR_STRING    = 5'd25;
   localparam logic [4:0] ERR_CHAR      = 5'd26;
   localparam logic [4:0] ERR_UNKNOWN   = 5'd27;

   // byte codes
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_LCURLY = 8'h7B;
   localparam logic [7:0] CH_RCURLY = 8'h7D;

   typedef struct packed {
      logic [7:0] code;
      logic       digit;
      logic       alpha;   // letter or underscore
      logic       op;      // operator byte
   } char_type;

   typedef struct packed {
      char_type ch;
      logic     eos;
   } item_type;

   typedef struct packed {
      logic item_open;
      logic final_phase;
      logic held_valid;
   } core_status_type;

   function automatic char_type classify(input logic [7:0] b);
      char_type r;
      r.code  = b;
      r.digit = (b >= 8'h30) && (b <= 8'h39);
      r.alpha = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))
                || (b == 8'h5F);
      unique case (b)
         8'h2B, 8'h2D, 8'h2F, 8'h5C, 8'h2A, 8'h7E, 8'h3C, 8'h3E,
         8'h3D, 8'h40, 8'h2C, 8'h25, 8'h7C, 8'h26, 8'h3F, 8'h21: r.op = 1'b1;
         default: r.op = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] b);
      logic [4:0] k;
      unique case (b)
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_LBRACK: k = KIND_LBRACK;
         CH_RBRACK: k = KIND_RBRACK;
         CH_LCURLY: k = KIND_LCURLY;
         CH_RCURLY: k = KIND_RCURLY;
         CH_SEMI:   k = KIND_SEMI;
         CH_DOT:    k = KIND_DOT;
         default:   k = ERR_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### design/stc_front.sv
// Front end: takes request transfers, classes each byte and queues it.
// Depends on stc_pkg.
`default_nettype none

module stc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_char_byte,
   input  wire logic              req_end_of_source,
   output logic                   q_valid,
   output stc_pkg::item_type      q_item,
   input  wire logic              q_pop
);

   localparam int PTR_BITS = $clog2(stc_pkg::QUEUE_DEPTH);

   stc_pkg::item_type           slot_ff [stc_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]         head_ff, head_in;
   logic [PTR_BITS-1:0]         tail_ff, tail_in;
   logic [PTR_BITS:0]           count_ff, count_in;
   logic                        push;

   assign req_stall = (count_ff == (PTR_BITS+1)'(stc_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[head_ff];

   // advance pointers and occupancy
   always_comb begin
      head_in  = q_pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // store the classed byte
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff].ch  <= stc_pkg::classify(req_char_byte);
         slot_ff[tail_ff].eos <= req_end_of_source;
      end
   end

endmodule

`default_nettype wire

### design/stc_core.sv
// Back end: lookahead, position tracking, token scanner and result register.
// Depends on stc_pkg.
`default_nettype none

module stc_core #(
   parameter int INDEX_BITS  = 24,
   parameter int COLUMN_BITS = 16,
   parameter int TAB_STOP    = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  stc_pkg::item_type           q_item,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [4:0]                  rsp_token_kind,
   output logic [INDEX_BITS-1:0]       rsp_start_index,
   output logic [INDEX_BITS-1:0]       rsp_start_line,
   output logic [COLUMN_BITS-1:0]      rsp_start_column,
   output logic [INDEX_BITS-1:0]       rsp_end_index,
   output logic [INDEX_BITS-1:0]       rsp_end_line,
   output logic [COLUMN_BITS-1:0]      rsp_end_column,
   output logic                        rsp_last_of_run,
   output stc_pkg::core_status_type    status
);

   localparam int PW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam logic [INDEX_BITS-1:0]  IDX_MAX = {INDEX_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

   typedef struct packed {
      logic [INDEX_BITS-1:0]  index;
      logic [INDEX_BITS-1:0]  line;
      logic [COLUMN_BITS-1:0] col;
   } tpos_type;

   typedef struct packed {
      logic [4:0] kind;
      tpos_type   spos;
      tpos_type   epos;
      logic       last;
   } token_type;

   typedef enum logic [18:0] {
      MODE_IDLE       = 19'h00001,
      MODE_COMMENT    = 19'h00002,
      MODE_IDENT      = 19'h00004,
      MODE_KW_AFTER   = 19'h00008,
      MODE_KW_PART    = 19'h00010,
      MODE_KW_IDENT   = 19'h00020,
      MODE_SYM_OP     = 19'h00040,
      MODE_HASH_QUOTE = 19'h00080,
      MODE_TAKE_ONE   = 19'h00100,
      MODE_STRING     = 19'h00200,
      MODE_STR_DOUBLE = 19'h00400,
      MODE_STR_AFTER  = 19'h00800,
      MODE_NUM_INT    = 19'h01000,
      MODE_NUM_RADIX  = 19'h02000,
      MODE_NUM_FRAC   = 19'h04000,
      MODE_EXP_SIGN   = 19'h08000,
      MODE_NUM_EXP    = 19'h10000,
      MODE_BAR        = 19'h20000,
      MODE_OPER       = 19'h40000
   } mode_type;

   typedef enum logic [1:0] {
      PH_RUN   = 2'b01,
      PH_FINAL = 2'b10
   } phase_type;

   localparam tpos_type ORIGIN = '{index: '0, line: INDEX_BITS'(1), col: COLUMN_BITS'(1)};

   // state
   stc_pkg::char_type  la_ff [3];
   stc_pkg::char_type  la_in [3];
   logic [1:0]         cnt_ff, cnt_in;
   tpos_type           pos_ff, pos_in;
   logic [PW-1:0]      tphase_ff, tphase_in;
   logic               cr_ff, cr_in;
   mode_type           mode_ff, mode_in;
   tpos_type           start_ff, start_in;
   tpos_type           back_ff, back_in;
   logic               sym_ff, sym_in;
   logic               multi_ff, multi_in;
   logic [4:0]         pend_ff, pend_in;
   logic               open_ff, open_in;
   logic               eos_ff, eos_in;
   phase_type          phase_ff, phase_in;
   token_type          held_ff, held_in;
   logic               held_valid_ff, held_valid_in;
   token_type          rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // working signals
   logic               go, load, active;
   stc_pkg::char_type  la_e [3];
   logic [1:0]         cnt_e;
   logic               eos_e;
   stc_pkg::char_type  c, p1, p2;
   logic               h1, h2, w1, w2, ws;
   tpos_type           adv;
   logic [PW-1:0]      adv_tphase;
   logic               adv_cr;
   logic [COLUMN_BITS:0] tab_sum;
   logic               consume, wait_more, emit_new, done_now, start_set, push, clear;
   logic [4:0]         e_kind, chain;
   tpos_type           e_start, e_end;
   token_type          new_tok;

   assign go     = !(rsp_valid_ff && rsp_stall);
   assign load   = (phase_ff == PH_RUN) && !open_ff && q_valid;
   assign active = open_ff || load;
   assign q_pop  = go && load;
   assign chain  = sym_ff ? stc_pkg::KIND_SYMBOL
                          : (multi_ff ? stc_pkg::KIND_MULTI : stc_pkg::KIND_KEYWORD);

   // append the incoming byte to the lookahead
   always_comb begin
      la_e[0] = la_ff[0];
      la_e[1] = la_ff[1];
      la_e[2] = la_ff[2];
      cnt_e   = cnt_ff;
      eos_e   = load ? q_item.eos : eos_ff;
      if (load && !q_item.eos) begin
         la_e[cnt_ff] = q_item.ch;
         cnt_e        = cnt_ff + 2'd1;
      end
   end

   assign c  = la_e[0];
   assign p1 = la_e[1];
   assign p2 = la_e[2];
   assign h1 = (cnt_e >= 2'd2);
   assign h2 = (cnt_e == 2'd3);
   assign w1 = !h1 && !eos_e;
   assign w2 = !h2 && !eos_e;
   assign ws = (c.code <= stc_pkg::CH_SPACE);

   // position after taking the head byte
   always_comb begin
      adv        = pos_ff;
      adv_tphase = tphase_ff;
      adv_cr     = 1'b0;
      tab_sum    = {1'b0, pos_ff.col} + (COLUMN_BITS+1)'(TAB_STOP)
                   - (COLUMN_BITS+1)'(tphase_ff);
      if (pos_ff.index != IDX_MAX) adv.index = pos_ff.index + 1'b1;
      if (c.code == stc_pkg::CH_CR) begin
         if (pos_ff.line != IDX_MAX) adv.line = pos_ff.line + 1'b1;
         adv.col    = COLUMN_BITS'(1);
         adv_tphase = '0;
         adv_cr     = 1'b1;
      end else if (c.code == stc_pkg::CH_LF) begin
         if (!cr_ff) begin
            if (pos_ff.line != IDX_MAX) adv.line = pos_ff.line + 1'b1;
            adv.col    = COLUMN_BITS'(1);
            adv_tphase = '0;
         end
      end else if (c.code == stc_pkg::CH_TAB) begin
         adv.col    = tab_sum[COLUMN_BITS] ? COL_MAX : tab_sum[COLUMN_BITS-1:0];
         adv_tphase = '0;
      end else if (pos_ff.col != COL_MAX) begin
         adv.col    = pos_ff.col + 1'b1;
         adv_tphase = (tphase_ff == PW'(TAB_STOP - 1)) ? '0 : tphase_ff + 1'b1;
      end
   end

   // one scanner step on the head byte, or the end-of-text flush
   always_comb begin
      consume   = 1'b0;
      wait_more = 1'b0;
      emit_new  = 1'b0;
      start_set = 1'b0;
      clear     = 1'b0;
      e_kind    = stc_pkg::KIND_END;
      e_start   = start_ff;
      e_end     = pos_ff;
      mode_in   = mode_ff;
      back_in   = back_ff;
      sym_in    = sym_ff;
      multi_in  = multi_ff;
      pend_in   = pend_ff;
      if (phase_ff == PH_FINAL) begin
         mode_in  = MODE_IDLE;
         emit_new = 1'b1;
         unique case (mode_ff)
            MODE_IDLE: begin
               e_start = pos_ff;
               clear   = 1'b1;
            end
            MODE_COMMENT:  e_kind = stc_pkg::ERR_COMMENT;
            MODE_IDENT:    e_kind = sym_ff ? stc_pkg::KIND_SYMBOL : stc_pkg::KIND_IDENT;
            MODE_KW_AFTER: e_kind = chain;
            MODE_KW_PART: begin
               e_kind  = chain;
               e_end   = back_ff;
               mode_in = MODE_KW_IDENT;
            end
            MODE_KW_IDENT: begin
               e_kind  = stc_pkg::KIND_IDENT;
               e_start = back_ff;
            end
            MODE_SYM_OP:   e_kind = stc_pkg::KIND_SYMBOL;
            MODE_HASH_QUOTE, MODE_STRING, MODE_STR_DOUBLE, MODE_STR_AFTER:
               e_kind = sym_ff ? stc_pkg::ERR_SYMSTR : stc_pkg::ERR_STRING;
            MODE_TAKE_ONE:
               e_kind = (pend_ff == stc_pkg::KIND_CHAR) ? stc_pkg::ERR_CHAR : pend_ff;
            MODE_NUM_INT, MODE_NUM_RADIX: e_kind = stc_pkg::KIND_INTEGER;
            MODE_NUM_FRAC, MODE_EXP_SIGN, MODE_NUM_EXP: e_kind = stc_pkg::KIND_FLOAT;
            MODE_BAR:      e_kind = stc_pkg::KIND_BAR;
            MODE_OPER:     e_kind = pend_ff;
            default: begin
               e_start = pos_ff;
               clear   = 1'b1;
            end
         endcase
      end else if (active && (cnt_e != 2'd0)) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               priority if (ws) begin
                  consume = 1'b1;
               end else if (((c.code == stc_pkg::CH_MINUS) || (c.code == stc_pkg::CH_HASH))
                            && w1) begin
                  wait_more = 1'b1;
               end else begin
                  start_set = 1'b1;
                  consume   = 1'b1;
                  priority if (c.code == stc_pkg::CH_DQUOTE) begin
                     mode_in = MODE_COMMENT;
                  end else if (c.alpha) begin
                     mode_in = MODE_IDENT;
                     sym_in  = 1'b0;
                  end else if (c.digit || ((c.code == stc_pkg::CH_MINUS) && h1 && p1.digit))
                     begin
                     mode_in = MODE_NUM_INT;
                  end else if (c.code == stc_pkg::CH_HASH) begin
                     sym_in = 1'b1;
                     priority if (h1 && p1.alpha) begin
                        mode_in = MODE_IDENT;
                     end else if (h1 && p1.op) begin
                        mode_in = MODE_SYM_OP;
                     end else if (h1 && (p1.code == stc_pkg::CH_QUOTE)) begin
                        mode_in = MODE_HASH_QUOTE;
                     end else if (h1 && (p1.code == stc_pkg::CH_LBRACK)) begin
                        pend_in = stc_pkg::KIND_BYTEARR;
                        mode_in = MODE_TAKE_ONE;
                     end else if (h1 && (p1.code == stc_pkg::CH_LPAREN)) begin
                        pend_in = stc_pkg::KIND_LITARR;
                        mode_in = MODE_TAKE_ONE;
                     end else begin
                        emit_new = 1'b1;
                        e_kind   = stc_pkg::ERR_UNKNOWN;
                        e_start  = pos_ff;
                        e_end    = adv;
                        mode_in  = MODE_IDLE;
                     end
                  end else if (c.code == stc_pkg::CH_QUOTE) begin
                     mode_in = MODE_STRING;
                     sym_in  = 1'b0;
                  end else if (c.code == stc_pkg::CH_DOLLAR) begin
                     mode_in = MODE_TAKE_ONE;
                     pend_in = stc_pkg::KIND_CHAR;
                  end else if (c.code == stc_pkg::CH_BAR) begin
                     mode_in = MODE_BAR;
                  end else if (c.op) begin
                     mode_in = MODE_OPER;
                     pend_in = (c.code == stc_pkg::CH_LT) ? stc_pkg::KIND_LT
                             : ((c.code == stc_pkg::CH_GT) ? stc_pkg::KIND_GT
                                                           : stc_pkg::KIND_OPER);
                  end else begin
                     emit_new = 1'b1;
                     e_kind   = stc_pkg::single_kind(c.code);
                     e_start  = pos_ff;
                     e_end    = adv;
                  end
               end
            end
            MODE_COMMENT: begin
               consume = 1'b1;
               if (c.code == stc_pkg::CH_DQUOTE) mode_in = MODE_IDLE;
            end
            MODE_IDENT: begin
               priority if (c.alpha || c.digit) begin
                  consume = 1'b1;
               end else if (c.code == stc_pkg::CH_COLON) begin
                  consume  = 1'b1;
                  multi_in = 1'b0;
                  mode_in  = MODE_KW_AFTER;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = sym_ff ? stc_pkg::KIND_SYMBOL : stc_pkg::KIND_IDENT;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_KW_AFTER: begin
               if (c.alpha) begin
                  back_in = pos_ff;
                  consume = 1'b1;
                  mode_in = MODE_KW_PART;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = chain;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_KW_PART: begin
               priority if (c.alpha || c.digit) begin
                  consume = 1'b1;
               end else if (c.code == stc_pkg::CH_COLON) begin
                  consume  = 1'b1;
                  multi_in = 1'b1;
                  mode_in  = MODE_KW_AFTER;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = chain;
                  e_end    = back_ff;
                  mode_in  = MODE_KW_IDENT;
               end
            end
            MODE_KW_IDENT: begin
               emit_new = 1'b1;
               e_kind   = stc_pkg::KIND_IDENT;
               e_start  = back_ff;
               mode_in  = MODE_IDLE;
            end
            MODE_SYM_OP: begin
               if (c.op) begin
                  consume = 1'b1;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = stc_pkg::KIND_SYMBOL;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_HASH_QUOTE: begin
               consume = 1'b1;
               mode_in = MODE_STRING;
            end
            MODE_TAKE_ONE: begin
               consume  = 1'b1;
               emit_new = 1'b1;
               e_kind   = pend_ff;
               e_end    = adv;
               mode_in  = MODE_IDLE;
            end
            MODE_STRING: begin
               priority if ((c.code == stc_pkg::CH_QUOTE) && w1) begin
                  wait_more = 1'b1;
               end else if ((c.code == stc_pkg::CH_QUOTE) && h1
                            && (p1.code == stc_pkg::CH_QUOTE)) begin
                  consume = 1'b1;
                  mode_in = MODE_STR_DOUBLE;
               end else if (c.code == stc_pkg::CH_QUOTE) begin
                  consume  = 1'b1;
                  emit_new = 1'b1;
                  e_kind   = sym_ff ? stc_pkg::KIND_SYMBOL : stc_pkg::KIND_STRING;
                  e_end    = adv;
                  mode_in  = MODE_IDLE;
               end else begin
                  consume = 1'b1;
               end
            end
            MODE_STR_DOUBLE: begin
               consume = 1'b1;
               mode_in = MODE_STR_AFTER;
            end
            MODE_STR_AFTER: begin
               consume = 1'b1;
               if (c.code == stc_pkg::CH_QUOTE) begin
                  emit_new = 1'b1;
                  e_kind   = sym_ff ? stc_pkg::KIND_SYMBOL : stc_pkg::KIND_STRING;
                  e_end    = adv;
                  mode_in  = MODE_IDLE;
               end else begin
                  mode_in = MODE_STRING;
               end
            end
            MODE_NUM_INT: begin
               priority if (c.digit) begin
                  consume = 1'b1;
               end else if (c.code == stc_pkg::CH_LOWER_R) begin
                  consume = 1'b1;
                  mode_in = MODE_NUM_RADIX;
               end else if ((c.code == stc_pkg::CH_DOT) && w1) begin
                  wait_more = 1'b1;
               end else if ((c.code == stc_pkg::CH_DOT) && h1 && p1.digit) begin
                  consume = 1'b1;
                  mode_in = MODE_NUM_FRAC;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = stc_pkg::KIND_INTEGER;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_NUM_RADIX: begin
               if (c.alpha || c.digit) begin
                  consume = 1'b1;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = stc_pkg::KIND_INTEGER;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_NUM_FRAC: begin
               priority if (c.digit) begin
                  consume = 1'b1;
               end else if ((c.code == stc_pkg::CH_LOWER_E)
                            || (c.code == stc_pkg::CH_UPPER_E)) begin
                  priority if (w1) begin
                     wait_more = 1'b1;
                  end else if (h1 && p1.digit) begin
                     consume = 1'b1;
                     mode_in = MODE_NUM_EXP;
                  end else if (h1 && ((p1.code == stc_pkg::CH_PLUS)
                                      || (p1.code == stc_pkg::CH_MINUS)) && w2) begin
                     wait_more = 1'b1;
                  end else if (h1 && ((p1.code == stc_pkg::CH_PLUS)
                                      || (p1.code == stc_pkg::CH_MINUS)) && h2 && p2.digit)
                     begin
                     consume = 1'b1;
                     mode_in = MODE_EXP_SIGN;
                  end else begin
                     emit_new = 1'b1;
                     e_kind   = stc_pkg::KIND_FLOAT;
                     mode_in  = MODE_IDLE;
                  end
               end else begin
                  emit_new = 1'b1;
                  e_kind   = stc_pkg::KIND_FLOAT;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_EXP_SIGN: begin
               consume = 1'b1;
               mode_in = MODE_NUM_EXP;
            end
            MODE_NUM_EXP: begin
               if (c.digit) begin
                  consume = 1'b1;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = stc_pkg::KIND_FLOAT;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_BAR: begin
               if (c.op) begin
                  consume = 1'b1;
                  pend_in = stc_pkg::KIND_OPER;
                  mode_in = MODE_OPER;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = stc_pkg::KIND_BAR;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_OPER: begin
               if (c.op) begin
                  consume = 1'b1;
                  pend_in = stc_pkg::KIND_OPER;
               end else begin
                  emit_new = 1'b1;
                  e_kind   = pend_ff;
                  mode_in  = MODE_IDLE;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase
      end
   end

   // lookahead, position, item progress
   always_comb begin
      la_in[0]  = la_e[0];
      la_in[1]  = la_e[1];
      la_in[2]  = la_e[2];
      cnt_in    = cnt_e;
      pos_in    = pos_ff;
      tphase_in = tphase_ff;
      cr_in     = cr_ff;
      start_in  = start_set ? pos_ff : start_ff;
      eos_in    = eos_e;
      open_in   = open_ff;
      phase_in  = phase_ff;
      done_now  = 1'b0;
      if (phase_ff == PH_FINAL) begin
         if (clear) begin
            done_now = 1'b1;
            open_in  = 1'b0;
            phase_in = PH_RUN;
         end
      end else if (active) begin
         open_in = 1'b1;
         if ((cnt_e == 2'd0) || wait_more) begin
            if (eos_e) begin
               phase_in = PH_FINAL;
            end else begin
               done_now = 1'b1;
               open_in  = 1'b0;
            end
         end else if (consume) begin
            la_in[0]  = la_e[1];
            la_in[1]  = la_e[2];
            cnt_in    = cnt_e - 2'd1;
            pos_in    = adv;
            tphase_in = adv_tphase;
            cr_in     = adv_cr;
            if ((cnt_e == 2'd1) && !eos_e) begin
               done_now = 1'b1;
               open_in  = 1'b0;
            end
         end
      end
   end

   // hold the newest token until it is known whether it ends the run
   always_comb begin
      new_tok.kind = e_kind;
      new_tok.spos = e_start;
      new_tok.epos = e_end;
      new_tok.last = done_now;
      push         = held_valid_ff && (held_ff.last || emit_new || done_now);
      rsp_in       = held_ff;
      rsp_in.last  = held_ff.last || (done_now && !emit_new);
      rsp_valid_in = push;
      held_in      = emit_new ? new_tok : held_ff;
      held_valid_in = emit_new || (held_valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset || (go && clear)) begin
         cnt_ff    <= '0;
         pos_ff    <= ORIGIN;
         tphase_ff <= '0;
         cr_ff     <= 1'b0;
         mode_ff   <= MODE_IDLE;
         start_ff  <= ORIGIN;
         back_ff   <= ORIGIN;
         sym_ff    <= 1'b0;
         multi_ff  <= 1'b0;
         pend_ff   <= stc_pkg::KIND_OPER;
         open_ff   <= 1'b0;
         eos_ff    <= 1'b0;
         phase_ff  <= PH_RUN;
      end else if (go) begin
         cnt_ff    <= cnt_in;
         pos_ff    <= pos_in;
         tphase_ff <= tphase_in;
         cr_ff     <= cr_in;
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         back_ff   <= back_in;
         sym_ff    <= sym_in;
         multi_ff  <= multi_in;
         pend_ff   <= pend_in;
         open_ff   <= open_in;
         eos_ff    <= eos_in;
         phase_ff  <= phase_in;
      end
   end

   // result handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (go) begin
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (go) begin
         la_ff[0] <= la_in[0];
         la_ff[1] <= la_in[1];
         la_ff[2] <= la_in[2];
         held_ff  <= held_in;
         if (push) rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_token_kind     = rsp_ff.kind;
   assign rsp_start_index    = rsp_ff.spos.index;
   assign rsp_start_line     = rsp_ff.spos.line;
   assign rsp_start_column   = rsp_ff.spos.col;
   assign rsp_end_index      = rsp_ff.epos.index;
   assign rsp_end_line       = rsp_ff.epos.line;
   assign rsp_end_column     = rsp_ff.epos.col;
   assign rsp_last_of_run    = rsp_ff.last;

   assign status.item_open   = open_ff;
   assign status.final_phase = (phase_ff == PH_FINAL);
   assign status.held_valid  = held_valid_ff;

endmodule

`default_nettype wire

### design/source_token_scanner_top.sv
// Source token scanner: one byte per transfer in, tokens with positions out.
// Throughput: one byte per cycle while rsp_stall is low, but a byte that ends a token stays
// at the head and is scanned again; an end marker flushes the token under way, then ends the run.
// Reset: synchronous, clears the queue, lookahead, positions and results.
// Depends on stc_pkg, stc_front, stc_core and source_token_scanner_top_assert.svh.
`default_nettype none

`include "source_token_scanner_top_assert.svh"

module source_token_scanner_top #(
   parameter int INDEX_BITS  = 24,
   parameter int COLUMN_BITS = 16,
   parameter int TAB_STOP    = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_char_byte,
   input  wire logic                   req_end_of_source,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [4:0]                  rsp_token_kind,
   output logic [INDEX_BITS-1:0]       rsp_start_index,
   output logic [INDEX_BITS-1:0]       rsp_start_line,
   output logic [COLUMN_BITS-1:0]      rsp_start_column,
   output logic [INDEX_BITS-1:0]       rsp_end_index,
   output logic [INDEX_BITS-1:0]       rsp_end_line,
   output logic [COLUMN_BITS-1:0]      rsp_end_column,
   output logic                        rsp_last_of_run
);

   logic                      q_valid;
   logic                      q_pop;
   stc_pkg::item_type         q_item;
   stc_pkg::core_status_type  status;

   // queue of classed bytes
   stc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_byte     (req_char_byte),
      .req_end_of_source (req_end_of_source),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   // scanner and result register
   stc_core #(
      .INDEX_BITS  (INDEX_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .TAB_STOP    (TAB_STOP)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_index  (rsp_start_index),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_end_index    (rsp_end_index),
      .rsp_end_line     (rsp_end_line),
      .rsp_end_column   (rsp_end_column),
      .rsp_last_of_run  (rsp_last_of_run),
      .status           (status)
   );

   `STS_ASSERT_IMPL(a_pop_needs_item, q_pop, q_valid, "pop from empty queue")
   `STS_ASSERT_IMPL(a_final_in_item, status.final_phase, status.item_open, "flush outside item")
   `STS_ASSERT_IMPL(a_no_pop_in_item, status.item_open, !q_pop, "pop while item open")
   `STS_ASSERT_NEXT(a_reset_clears, reset, !rsp_valid && !status.held_valid, "reset left result")

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for source_token_scanner_top: streams text bytes and
// end markers in, predicts every token with its positions, checks each transfer.
// Depends on stc_pkg and the scanner RTL only.
`timescale 1ns / 100ps

module testbench;

   localparam int LIMIT = 400000;
   localparam int PEEK_EOF = -1;
   localparam int PEEK_WAIT = -2;

   typedef enum int {
      S_IDLE, S_COMMENT, S_IDENT, S_KW_AFTER, S_KW_PART, S_SYM_OP, S_HASH_QUOTE,
      S_TAKE_ONE, S_STRING, S_STR_DOUBLED, S_STR_AFTER, S_NUM_INT, S_NUM_RADIX,
      S_NUM_FRAC, S_EXP_SIGN, S_NUM_EXP, S_BAR, S_OPER
   } scan_state_type;

   typedef struct {
      logic [23:0] idx;
      logic [23:0] line;
      logic [15:0] col;
   } place_type;

   typedef struct {
      logic [4:0] kind;
      place_type  from;
      place_type  upto;
      logic       last;
   } token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = 8'd0;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [23:0] rsp_start_index, rsp_start_line, rsp_end_index, rsp_end_line;
   logic [15:0] rsp_start_column, rsp_end_column;
   logic        rsp_last_of_run;

   token_type   token_q[$];
   int          errors = 0;
   bit          calm = 1'b0;

   // scanner copy
   logic [7:0]     held[3];
   int             held_cnt;
   place_type      here, tok_start, kw_back;
   bit             prev_cr, sym_flag, multi_flag;
   scan_state_type mode;
   logic [4:0]     pend_kind;
   int             step_cnt;

   source_token_scanner_top dut (.*);

   always #5 clock = ~clock;

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   // -------------------------------------------------------------- predictor
   function automatic bit is_digit(int c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_start(int c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic bit is_mid(int c);
      return is_start(c) || is_digit(c);
   endfunction

   function automatic bit is_op(int c);
      return c inside {"+", "-", "/", "\\", "*", "~", "<", ">", "=", "@", ",", "%",
                       "|", "&", "?", "!"};
   endfunction

   function automatic void clear_scan();
      place_type origin;
      origin.idx = 24'd0;
      origin.line = 24'd1;
      origin.col = 16'd1;
      held_cnt = 0;
      here = origin;
      tok_start = origin;
      kw_back = origin;
      prev_cr = 0;
      sym_flag = 0;
      multi_flag = 0;
      mode = S_IDLE;
      pend_kind = stc_pkg::KIND_OPER;
   endfunction

   // advance the position over one byte, saturating
   function automatic void move_over(int c);
      int t;
      if (here.idx != 24'hFFFFFF) here.idx++;
      if (c == stc_pkg::CH_CR) begin
         if (here.line != 24'hFFFFFF) here.line++;
         here.col = 16'd1;
         prev_cr = 1;
         return;
      end
      if (c == stc_pkg::CH_LF) begin
         if (!prev_cr) begin
            if (here.line != 24'hFFFFFF) here.line++;
            here.col = 16'd1;
         end
      end else if (c == stc_pkg::CH_TAB) begin
         t = ((int'(here.col) - 1) / 4 + 1) * 4 + 1;
         here.col = t > 65535 ? 16'hFFFF : 16'(t);
      end else if (here.col != 16'hFFFF) begin
         here.col++;
      end
      prev_cr = 0;
   endfunction

   function automatic void push_token(logic [4:0] k, place_type f, place_type u);
      token_type t;
      if (step_cnt >= 4) return;
      t.kind = k;
      t.from = f;
      t.upto = u;
      t.last = 0;
      token_q.push_back(t);
      step_cnt++;
   endfunction

   function automatic void open_tok(scan_state_type m);
      tok_start = here;
      mode = m;
   endfunction

   function automatic void close_tok(logic [4:0] k);
      push_token(k, tok_start, here);
      mode = S_IDLE;
   endfunction

   function automatic logic [4:0] chain_kind();
      return sym_flag ? stc_pkg::KIND_SYMBOL
                      : (multi_flag ? stc_pkg::KIND_MULTI : stc_pkg::KIND_KEYWORD);
   endfunction

   function automatic logic [4:0] lone_kind(int c);
      case (c)
         stc_pkg::CH_LPAREN: return stc_pkg::KIND_LPAREN;
         stc_pkg::CH_RPAREN: return stc_pkg::KIND_RPAREN;
         stc_pkg::CH_LBRACK: return stc_pkg::KIND_LBRACK;
         stc_pkg::CH_RBRACK: return stc_pkg::KIND_RBRACK;
         stc_pkg::CH_LCURLY: return stc_pkg::KIND_LCURLY;
         stc_pkg::CH_RCURLY: return stc_pkg::KIND_RCURLY;
         stc_pkg::CH_SEMI:   return stc_pkg::KIND_SEMI;
         stc_pkg::CH_DOT:    return stc_pkg::KIND_DOT;
         default:            return stc_pkg::ERR_UNKNOWN;
      endcase
   endfunction

   // consume c when the lookahead decides it; 0 means wait for more bytes
   function automatic bit scan_byte(int c, int p1, int p2);
      while (1) begin
         case (mode)
            S_IDLE: begin
               if (c <= 32) begin move_over(c); return 1; end
               if ((c == stc_pkg::CH_MINUS || c == stc_pkg::CH_HASH) && p1 == PEEK_WAIT)
                  return 0;
               if (c == stc_pkg::CH_DQUOTE) begin
                  open_tok(S_COMMENT); move_over(c); return 1;
               end
               if (is_start(c)) begin
                  open_tok(S_IDENT); sym_flag = 0; move_over(c); return 1;
               end
               if (is_digit(c) || (c == stc_pkg::CH_MINUS && is_digit(p1))) begin
                  open_tok(S_NUM_INT); move_over(c); return 1;
               end
               if (c == stc_pkg::CH_HASH) begin
                  open_tok(S_IDLE);
                  move_over(c);
                  sym_flag = 1;
                  if (is_start(p1)) mode = S_IDENT;
                  else if (is_op(p1)) mode = S_SYM_OP;
                  else if (p1 == stc_pkg::CH_QUOTE) mode = S_HASH_QUOTE;
                  else if (p1 == stc_pkg::CH_LBRACK) begin
                     pend_kind = stc_pkg::KIND_BYTEARR; mode = S_TAKE_ONE;
                  end
                  else if (p1 == stc_pkg::CH_LPAREN) begin
                     pend_kind = stc_pkg::KIND_LITARR; mode = S_TAKE_ONE;
                  end
                  else close_tok(stc_pkg::ERR_UNKNOWN);
                  return 1;
               end
               if (c == stc_pkg::CH_QUOTE) begin
                  open_tok(S_STRING); sym_flag = 0; move_over(c); return 1;
               end
               if (c == stc_pkg::CH_DOLLAR) begin
                  open_tok(S_TAKE_ONE); pend_kind = stc_pkg::KIND_CHAR; move_over(c); return 1;
               end
               if (c == stc_pkg::CH_BAR) begin open_tok(S_BAR); move_over(c); return 1; end
               if (is_op(c)) begin
                  open_tok(S_OPER);
                  pend_kind = c == stc_pkg::CH_LT ? stc_pkg::KIND_LT
                            : (c == stc_pkg::CH_GT ? stc_pkg::KIND_GT : stc_pkg::KIND_OPER);
                  move_over(c);
                  return 1;
               end
               open_tok(S_IDLE);
               move_over(c);
               close_tok(lone_kind(c));
               return 1;
            end
            S_COMMENT: begin
               move_over(c);
               if (c == stc_pkg::CH_DQUOTE) mode = S_IDLE;
               return 1;
            end
            S_IDENT: begin
               if (is_mid(c)) begin move_over(c); return 1; end
               if (c == stc_pkg::CH_COLON) begin
                  move_over(c); multi_flag = 0; mode = S_KW_AFTER; return 1;
               end
               close_tok(sym_flag ? stc_pkg::KIND_SYMBOL : stc_pkg::KIND_IDENT);
            end
            S_KW_AFTER: begin
               if (is_start(c)) begin
                  kw_back = here; move_over(c); mode = S_KW_PART; return 1;
               end
               close_tok(chain_kind());
            end
            S_KW_PART: begin
               if (is_mid(c)) begin move_over(c); return 1; end
               if (c == stc_pkg::CH_COLON) begin
                  move_over(c); multi_flag = 1; mode = S_KW_AFTER; return 1;
               end
               push_token(chain_kind(), tok_start, kw_back);
               push_token(stc_pkg::KIND_IDENT, kw_back, here);
               mode = S_IDLE;
            end
            S_SYM_OP: begin
               if (is_op(c)) begin move_over(c); return 1; end
               close_tok(stc_pkg::KIND_SYMBOL);
            end
            S_HASH_QUOTE: begin move_over(c); mode = S_STRING; return 1; end
            S_TAKE_ONE: begin move_over(c); close_tok(pend_kind); return 1; end
            S_STRING: begin
               if (c == stc_pkg::CH_QUOTE) begin
                  if (p1 == PEEK_WAIT) return 0;
                  move_over(c);
                  if (p1 == stc_pkg::CH_QUOTE) mode = S_STR_DOUBLED;
                  else close_tok(sym_flag ? stc_pkg::KIND_SYMBOL : stc_pkg::KIND_STRING);
                  return 1;
               end
               move_over(c);
               return 1;
            end
            S_STR_DOUBLED: begin move_over(c); mode = S_STR_AFTER; return 1; end
            S_STR_AFTER: begin
               move_over(c);
               if (c == stc_pkg::CH_QUOTE)
                  close_tok(sym_flag ? stc_pkg::KIND_SYMBOL : stc_pkg::KIND_STRING);
               else mode = S_STRING;
               return 1;
            end
            S_NUM_INT: begin
               if (is_digit(c)) begin move_over(c); return 1; end
               if (c == stc_pkg::CH_LOWER_R) begin
                  move_over(c); mode = S_NUM_RADIX; return 1;
               end
               if (c == stc_pkg::CH_DOT) begin
                  if (p1 == PEEK_WAIT) return 0;
                  if (is_digit(p1)) begin move_over(c); mode = S_NUM_FRAC; return 1; end
               end
               close_tok(stc_pkg::KIND_INTEGER);
            end
            S_NUM_RADIX: begin
               if (is_mid(c)) begin move_over(c); return 1; end
               close_tok(stc_pkg::KIND_INTEGER);
            end
            S_NUM_FRAC: begin
               if (is_digit(c)) begin move_over(c); return 1; end
               if (c == stc_pkg::CH_LOWER_E || c == stc_pkg::CH_UPPER_E) begin
                  if (p1 == PEEK_WAIT) return 0;
                  if (is_digit(p1)) begin move_over(c); mode = S_NUM_EXP; return 1; end
                  if (p1 == stc_pkg::CH_PLUS || p1 == stc_pkg::CH_MINUS) begin
                     if (p2 == PEEK_WAIT) return 0;
                     if (is_digit(p2)) begin move_over(c); mode = S_EXP_SIGN; return 1; end
                  end
               end
               close_tok(stc_pkg::KIND_FLOAT);
            end
            S_EXP_SIGN: begin move_over(c); mode = S_NUM_EXP; return 1; end
            S_NUM_EXP: begin
               if (is_digit(c)) begin move_over(c); return 1; end
               close_tok(stc_pkg::KIND_FLOAT);
            end
            S_BAR: begin
               if (is_op(c)) begin
                  move_over(c); pend_kind = stc_pkg::KIND_OPER; mode = S_OPER; return 1;
               end
               close_tok(stc_pkg::KIND_BAR);
            end
            S_OPER: begin
               if (is_op(c)) begin
                  move_over(c); pend_kind = stc_pkg::KIND_OPER; return 1;
               end
               close_tok(pend_kind);
            end
            default: mode = S_IDLE;
         endcase
      end
      return 1;
   endfunction

   // flush the token under way at end of text
   function automatic void flush_at_end();
      case (mode)
         S_COMMENT: close_tok(stc_pkg::ERR_COMMENT);
         S_IDENT: close_tok(sym_flag ? stc_pkg::KIND_SYMBOL : stc_pkg::KIND_IDENT);
         S_KW_AFTER: close_tok(chain_kind());
         S_KW_PART: begin
            push_token(chain_kind(), tok_start, kw_back);
            push_token(stc_pkg::KIND_IDENT, kw_back, here);
         end
         S_SYM_OP: close_tok(stc_pkg::KIND_SYMBOL);
         S_HASH_QUOTE, S_STRING, S_STR_DOUBLED, S_STR_AFTER:
            close_tok(sym_flag ? stc_pkg::ERR_SYMSTR : stc_pkg::ERR_STRING);
         S_TAKE_ONE:
            close_tok(pend_kind == stc_pkg::KIND_CHAR ? stc_pkg::ERR_CHAR : pend_kind);
         S_NUM_INT, S_NUM_RADIX: close_tok(stc_pkg::KIND_INTEGER);
         S_NUM_FRAC, S_EXP_SIGN, S_NUM_EXP: close_tok(stc_pkg::KIND_FLOAT);
         S_BAR: close_tok(stc_pkg::KIND_BAR);
         S_OPER: close_tok(pend_kind);
         default: ;
      endcase
      mode = S_IDLE;
   endfunction

   // work out the tokens one accepted transfer causes
   function automatic void predict_tokens(logic [7:0] b, logic eos);
      int p1, p2;
      step_cnt = 0;
      if (!eos && held_cnt < 3) begin
         held[held_cnt] = b;
         held_cnt++;
      end
      while (held_cnt > 0) begin
         p1 = held_cnt > 1 ? int'(held[1]) : (eos ? PEEK_EOF : PEEK_WAIT);
         p2 = held_cnt > 2 ? int'(held[2]) : (eos ? PEEK_EOF : PEEK_WAIT);
         if (!scan_byte(int'(held[0]), p1, p2)) break;
         held[0] = held[1];
         held[1] = held[2];
         held_cnt--;
      end
      if (eos) begin
         flush_at_end();
         push_token(stc_pkg::KIND_END, here, here);
         clear_scan();
      end
      if (step_cnt > 0) token_q[token_q.size() - 1].last = 1;
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic send_item(logic [7:0] b, logic eos);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_byte <= b;
      req_end_of_source <= eos;
      do @(posedge clock); while (req_stall);
      predict_tokens(b, eos);
   endtask

   task automatic send_text(string s, bit close_it);
      foreach (s[i]) send_item(s[i], 1'b0);
      if (close_it) send_item(8'($urandom), 1'b1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      token_type t;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_q.size() == 0) begin
            report_mismatch("token with nothing pending, kind", 32'(rsp_token_kind), 32'(0));
         end else begin
            t = token_q.pop_front();
            if (rsp_token_kind !== t.kind)
               report_mismatch("kind", 32'(rsp_token_kind), 32'(t.kind));
            if (rsp_start_index !== t.from.idx)
               report_mismatch("start index", 32'(rsp_start_index), 32'(t.from.idx));
            if (rsp_start_line !== t.from.line)
               report_mismatch("start line", 32'(rsp_start_line), 32'(t.from.line));
            if (rsp_start_column !== t.from.col)
               report_mismatch("start column", 32'(rsp_start_column), 32'(t.from.col));
            if (rsp_end_index !== t.upto.idx)
               report_mismatch("end index", 32'(rsp_end_index), 32'(t.upto.idx));
            if (rsp_end_line !== t.upto.line)
               report_mismatch("end line", 32'(rsp_end_line), 32'(t.upto.line));
            if (rsp_end_column !== t.upto.col)
               report_mismatch("end column", 32'(rsp_end_column), 32'(t.upto.col));
            if (rsp_last_of_run !== t.last)
               report_mismatch("last of run", 32'(rsp_last_of_run), 32'(t.last));
         end
      end
   end

   // receiver hold-off, redrawn after every transfer
   int hold_left = 0;
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) hold_left = draw_wait();
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("testbench NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------ tests
   task automatic test_tokens();
      send_text("foo at:put: 12 3.5 1.5e-3 2e 7E+1x -7 - 16r1F x.y; 4.", 1);
      send_text("(a)[b]{c} | |+ <= < > >> + !", 1);
      send_text("a:b:c a:b:1 x:b", 1);
   endtask

   task automatic test_specials();
      send_text("\"\" \"note\" 'it''s' 'a''''b' #sym #+- #'s q' #[ #( #) $a $", 1);
      send_text("x\ty\t\tz\r\nw\rv\nu\r\r", 1);
      send_item(8'd0, 1'b0);
      send_item(8'd128, 1'b0);
      send_item(8'd255, 1'b0);
      send_item(8'd32, 1'b0);
      send_item(8'h7F, 1'b0);
      send_text("#'open", 1);
      send_text("'open", 1);
      send_text("\"open", 1);
      send_text("#k:", 1);
   endtask

   function automatic string rand_word(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++)
         s = {s, string'(8'($urandom_range(0, 1) ? $urandom_range("a", "z") : "_"))};
      return s;
   endfunction

   function automatic string rand_digits(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
      return s;
   endfunction

   function automatic string rand_piece();
      string ops;
      ops = "+-/\\*~<>=@,%|&?!";
      case ($urandom_range(0, 14))
         0: return rand_word($urandom_range(1, 4));
         1: return {rand_word(2), ":", rand_word(2), ":"};
         2: return rand_digits($urandom_range(1, 3));
         3: return {rand_digits(1), ".", rand_digits(2), "e-", rand_digits(1)};
         4: return {"'", rand_word(2), "''", rand_word(1), "'"};
         5: return {"\"", rand_word(3), "\""};
         6: return {"#", rand_word(2)};
         7: return {"$", string'(8'($urandom_range(33, 126)))};
         8: return string'(ops[$urandom_range(0, 15)]);
         9: return "()[]{};.|#[#(";
         10: return "\t";
         11: return $urandom_range(0, 1) ? "\r\n" : "\n";
         12: return "16rA0";
         13: return string'(8'($urandom_range(1, 255)));
         default: return " ";
      endcase
   endfunction

   task automatic test_random_text();
      int sent;
      string s;
      sent = 0;
      while (sent < 130) begin
         s = "";
         while (s.len() < $urandom_range(5, 40)) s = {s, rand_piece()};
         // broken or raw bytes now and then, incl. NUL
         if ($urandom_range(0, 7) == 0) begin
            send_item(8'($urandom), 1'b0);
            sent++;
         end
         send_text(s, $urandom_range(0, 3) != 0);
         sent += s.len() + 1;
         calm = $urandom_range(0, 4) == 0;
         if ($urandom_range(0, 5) == 0) drain();
      end
      calm = 0;
      send_item(8'($urandom), 1'b1);
   endtask

   initial begin
      clear_scan();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tokens();
      test_specials();
      drain();
      test_random_text();
      req_valid <= 1'b0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && token_q.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
